[design/aes_pkg.sv]
// ----------------------------------------------------------------------------
// AES counter-mode package
// Payload types, register indexes, S-box table and round helper functions.
// ----------------------------------------------------------------------------
package aes_pkg;

  typedef struct packed {
    logic [63:0] counter_high;
    logic [63:0] counter_low;
    logic [63:0] data_high;
    logic [63:0] data_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] keystream_high;
    logic [63:0] keystream_low;
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_item_t;

  localparam int NumRounds = 14;
  localparam int NumRk     = NumRounds + 1;
  localparam int NumWords  = 4 * NumRk;

  localparam logic [2:0] RegKeySize = 3'd0;
  localparam logic [2:0] RegKey0    = 3'd1;
  localparam logic [2:0] RegKey1    = 3'd2;
  localparam logic [2:0] RegKey2    = 3'd3;
  localparam logic [2:0] RegKey3    = 3'd4;

  localparam logic [1:0] Ks128 = 2'd0;
  localparam logic [1:0] Ks192 = 2'd1;
  localparam logic [1:0] Ks256 = 2'd2;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // state byte i is at bits [127-8i -: 8]
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] o;
    o = '0;
    for (int i = 0; i < 16; i++) begin
      o[127-8*i -: 8] = SBOX[s[127-8*(4*(((i>>2)+(i&3))&3)+(i&3)) -: 8]];
    end
    sub_shift = o;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s);
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      o[127-32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      o[119-32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      o[111-32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      o[103-32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    mix_cols = o;
  endfunction

endpackage

[design/aes_key_expand.sv]
// ----------------------------------------------------------------------------
// AES key expansion
// Sequential schedule: one 32-bit word per cycle into a round-key store,
// restarted whenever the key or key size changes; the new key is taken in the
// cycle after the write that changed it.
// ----------------------------------------------------------------------------
module aes_key_expand import aes_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                restart,
  input  logic [1:0]          key_size,
  input  logic [255:0]        key,
  output logic                done,
  output logic [NumRk-1:0][127:0] round_keys
);

  logic [NumWords-1:0][31:0] words;
  logic [5:0] idx;
  logic [3:0] nk;
  logic [5:0] total;
  logic [2:0] pos;
  logic [7:0] rcon;
  logic [31:0] t, nw;
  logic        reload;

  always_comb begin
    case (key_size)
      Ks192:   begin nk = 4'd6; total = 6'd52; end
      Ks256:   begin nk = 4'd8; total = 6'd60; end
      default: begin nk = 4'd4; total = 6'd44; end
    endcase
  end

  always_comb begin
    t = words[idx - 6'd1];
    if (pos == 3'd0) begin
      t = sub_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
    end else if (nk == 4'd8 && pos == 3'd4) begin
      t = sub_word(t);
    end
    nw = words[idx - 6'(nk)] ^ t;
  end

  // key registers settle at the write edge, so the load waits for the next cycle
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      reload <= 1'b1;
      done   <= 1'b0;
    end else if (reload) begin
      reload <= 1'b0;
      idx    <= 6'(nk);
      pos    <= 3'd0;
      rcon   <= 8'h01;
      for (int i = 0; i < 8; i++) begin
        words[i] <= key[255-32*i -: 32];
      end
    end else if (!done) begin
      words[idx] <= nw;
      if (pos == 3'd0) begin
        rcon <= xtime(rcon);
      end
      pos <= (pos == 3'(nk - 4'd1)) ? 3'd0 : pos + 3'd1;
      idx <= idx + 6'd1;
      if (idx == total - 6'd1) begin
        done <= 1'b1;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < NumRk; r++) begin
      round_keys[r] = {words[4*r], words[4*r+1], words[4*r+2], words[4*r+3]};
    end
  end

endmodule

[design/aes_round_stage.sv]
// ----------------------------------------------------------------------------
// AES round stage
// One registered round with valid and stall; final round skips MixColumns.
// ----------------------------------------------------------------------------
module aes_round_stage import aes_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         advance,
  input  logic         in_valid,
  input  logic [127:0] in_state,
  input  logic [127:0] in_data,
  input  logic         in_done,
  input  logic         in_final,
  input  logic [127:0] stage_key,
  output logic         out_valid,
  output logic [127:0] out_state,
  output logic [127:0] out_data,
  output logic         out_done
);

  logic [127:0] ss;
  logic [127:0] nxt;

  always_comb begin
    ss  = sub_shift(in_state);
    nxt = (in_final ? ss : mix_cols(ss)) ^ stage_key;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  // a finished item passes through unchanged
  always_ff @(posedge clk) begin
    if (advance) begin
      out_state <= in_done ? in_state : nxt;
      out_data  <= in_data;
      out_done  <= in_done || in_final;
    end
  end

endmodule

[design/aes_block_keystream_xor.sv]
// ----------------------------------------------------------------------------
// AES counter-mode keystream and XOR
// Unrolled AES pipeline of 14 round stages with key schedule and output register.
// ----------------------------------------------------------------------------
// Path: whitening register, all round stages, output register, for every key size.
// Throughput: one item per cycle; the whole pipeline stalls while the output is held.
// Reset: key size and key clear to zero; after reset or any config write the
// schedule runs again, and no item is accepted until it is done.
module aes_block_keystream_xor import aes_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [63:0] cfg_data
);

  logic [1:0]   key_size;
  logic [255:0] key;
  logic         cfg_we;
  logic         ks_done;
  logic [NumRk-1:0][127:0] round_keys;
  logic [3:0]   nr;

  // pipeline: stage 0 is the whitening register, stages 1..14 rounds
  logic [NumRk-1:0]        v;
  logic [NumRk-1:0][127:0] st;
  logic [NumRk-1:0][127:0] dt;
  logic [NumRk-1:0]        lst;
  logic advance;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_size <= Ks128;
      key      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegKeySize: key_size <= cfg_data[1:0];
        RegKey0:    key[255:192] <= cfg_data;
        RegKey1:    key[191:128] <= cfg_data;
        RegKey2:    key[127:64]  <= cfg_data;
        RegKey3:    key[63:0]    <= cfg_data;
        default: ;
      endcase
    end
  end

  aes_key_expand u_key (
    .clk(clk), .rst(rst), .restart(cfg_we),
    .key_size(key_size), .key(key),
    .done(ks_done), .round_keys(round_keys)
  );

  always_comb begin
    case (key_size)
      Ks192:   nr = 4'd12;
      Ks256:   nr = 4'd14;
      default: nr = 4'd10;
    endcase
  end

  // the whole line moves when the output register is free
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance && ks_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (advance) begin
      v[0] <= in_valid && ks_done;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st[0]  <= {in_item.counter_high, in_item.counter_low} ^ round_keys[0];
      dt[0]  <= {in_item.data_high, in_item.data_low};
      lst[0] <= 1'b0;
    end
  end

  // items that finished early pass later stages unchanged
  for (genvar r = 1; r < NumRk; r++) begin : g_round
    aes_round_stage u_rnd (
      .clk(clk), .rst(rst), .advance(advance),
      .in_valid(v[r-1]), .in_state(st[r-1]), .in_data(dt[r-1]),
      .in_done(lst[r-1]), .in_final(nr == 4'(r)), .stage_key(round_keys[r]),
      .out_valid(v[r]), .out_state(st[r]), .out_data(dt[r]), .out_done(lst[r])
    );
  end

  // stage 0 has no finished marker; the round-r stage sets it when r == nr
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= v[NumRk-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item.keystream_high <= st[NumRk-1][127:64];
      out_item.keystream_low  <= st[NumRk-1][63:0];
      out_item.result_high    <= st[NumRk-1][127:64] ^ dt[NumRk-1][127:64];
      out_item.result_low     <= st[NumRk-1][63:0] ^ dt[NumRk-1][63:0];
    end
  end

endmodule
